### rtl/fbm_pkg.sv
`default_nettype none

package fbm_pkg;

    // hash multipliers
    localparam logic [63:0] HASH_K1 = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] HASH_K2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] HASH_K3 = 64'hBF58476D1CE4E5B9;

    // accumulator widths cover up to sixteen octaves
    localparam int SUM_W  = 36;
    localparam int NORM_W = 20;
    localparam int Q_W    = 16;

    localparam logic [15:0] AMP_INIT = 16'h8000;
    localparam logic [17:0] FADE_3   = 18'd196608;

    // configuration register indexes
    localparam logic [1:0] CFG_OCTAVES = 2'd0;
    localparam logic [1:0] CFG_LACUN   = 2'd1;
    localparam logic [1:0] CFG_GAIN    = 2'd2;

    localparam logic [3:0]  RST_OCTAVES = 4'd4;
    localparam logic [15:0] RST_LACUN   = 16'd8192;
    localparam logic [15:0] RST_GAIN    = 16'd32768;

    // partial products of a 64 x 64 multiply, low 64 bits only
    typedef struct packed {
        logic [63:0] lo;
        logic [31:0] hi;
    } t_pp;

    // data moved between octave cells
    typedef struct packed {
        logic              valid;
        logic [47:0]       cx;
        logic [47:0]       cy;
        logic [15:0]       amp;
        logic [SUM_W-1:0]  sum;
        logic [NORM_W-1:0] norm;
    } t_oct_bus;

    // data carried alongside the hash inside a cell
    typedef struct packed {
        logic [47:0]       cx;
        logic [47:0]       cy;
        logic [15:0]       amp_n;
        logic [15:0]       amp;
        logic [SUM_W-1:0]  sum;
        logic [NORM_W-1:0] norm;
    } t_carry;

    // data moved between divider cells
    typedef struct packed {
        logic              valid;
        logic [SUM_W-1:0]  rem;
        logic [NORM_W-1:0] norm;
        logic [Q_W-1:0]    q;
    } t_div_bus;

    function automatic t_pp fbm_pp(input logic [63:0] a, input logic [63:0] k);
        t_pp         r;
        logic [31:0] m1;
        logic [31:0] m2;
        r.lo = a[31:0] * k[31:0];
        m1   = a[63:32] * k[31:0];
        m2   = a[31:0] * k[63:32];
        r.hi = m1 + m2;
        return r;
    endfunction

    function automatic logic [63:0] fbm_pj(input t_pp p);
        return p.lo + {p.hi, 32'h0};
    endfunction

    // (a*(1-s) + b*s) >> 16
    function automatic logic [15:0] fbm_blend(input logic [15:0] a, input logic [15:0] b,
                                              input logic [15:0] s);
        logic [16:0] sc;
        logic [33:0] acc;
        sc  = 17'h10000 - {1'b0, s};
        acc = a * sc + b * s;
        return acc[31:16];
    endfunction

endpackage

`default_nettype wire

### rtl/fbm_octave_cell.sv
`default_nettype none

module fbm_octave_cell import fbm_pkg::*; #(
    parameter int HASH_OUT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic        i_active,
    input  wire logic [15:0] i_lac,
    input  wire logic [15:0] i_gain,
    input  wire t_oct_bus    i_bus,
    output t_oct_bus         o_bus
);

    localparam int          VSH   = (HASH_OUT_BITS >= 16) ? 0 : 16 - HASH_OUT_BITS;
    localparam logic [15:0] VMASK = 16'(32'hFFFF << VSH);

    logic        r_vld [1:7];
    t_carry      r_cr  [1:7];
    t_oct_bus    r_out;

    // stage 1: lattice, fade square, next-octave scaling
    logic [63:0] r1_ix, r1_ix1, r1_iy, r1_iy1;
    logic [15:0] r1_t2x, r1_t2y;
    logic [17:0] r1_kx, r1_ky;
    logic [63:0] n1_ix, n1_iy;
    logic [31:0] n1_sqx, n1_sqy, n1_ag;
    logic signed [64:0] n1_scx, n1_scy;
    t_carry      n1_cr;

    always_comb begin
        n1_ix  = {{32{i_bus.cx[47]}}, i_bus.cx[47:16]};
        n1_iy  = {{32{i_bus.cy[47]}}, i_bus.cy[47:16]};
        n1_sqx = i_bus.cx[15:0] * i_bus.cx[15:0];
        n1_sqy = i_bus.cy[15:0] * i_bus.cy[15:0];
        n1_scx = $signed(i_bus.cx) * $signed({1'b0, i_lac});
        n1_scy = $signed(i_bus.cy) * $signed({1'b0, i_lac});
        n1_ag  = i_bus.amp * i_gain;
        n1_cr.cx    = n1_scx[59:12];
        n1_cr.cy    = n1_scy[59:12];
        n1_cr.amp_n = n1_ag[31:16];
        n1_cr.amp   = i_bus.amp;
        n1_cr.sum   = i_bus.sum;
        n1_cr.norm  = i_bus.norm;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_ix  <= n1_ix;
            r1_ix1 <= n1_ix + 64'd1;
            r1_iy  <= n1_iy;
            r1_iy1 <= n1_iy + 64'd1;
            r1_t2x <= n1_sqx[31:16];
            r1_t2y <= n1_sqy[31:16];
            r1_kx  <= FADE_3 - {1'b0, i_bus.cx[15:0], 1'b0};
            r1_ky  <= FADE_3 - {1'b0, i_bus.cy[15:0], 1'b0};
        end
    end

    // stage 2: corner products, fade finish
    t_pp         r2_px0, r2_px1, r2_py0, r2_py1;
    logic [15:0] r2_sx, r2_sy;
    logic [33:0] n2_fx, n2_fy;

    always_comb begin
        n2_fx = r1_t2x * r1_kx;
        n2_fy = r1_t2y * r1_ky;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_px0 <= fbm_pp(r1_ix, HASH_K1);
            r2_px1 <= fbm_pp(r1_ix1, HASH_K1);
            r2_py0 <= fbm_pp(r1_iy, HASH_K2);
            r2_py1 <= fbm_pp(r1_iy1, HASH_K2);
            r2_sx  <= n2_fx[31:16];
            r2_sy  <= n2_fy[31:16];
        end
    end

    // stage 3: combine corners and first xorshift
    logic [63:0] r3_h [4];
    logic [15:0] r3_sx, r3_sy;
    logic [63:0] n3_x0, n3_x1, n3_y0, n3_y1;
    logic [63:0] n3_h [4];

    always_comb begin
        n3_x0 = fbm_pj(r2_px0);
        n3_x1 = fbm_pj(r2_px1);
        n3_y0 = fbm_pj(r2_py0);
        n3_y1 = fbm_pj(r2_py1);
        n3_h[0] = n3_x0 ^ n3_y0;
        n3_h[1] = n3_x1 ^ n3_y0;
        n3_h[2] = n3_x0 ^ n3_y1;
        n3_h[3] = n3_x1 ^ n3_y1;
        for (int i = 0; i < 4; i++) begin
            n3_h[i] = n3_h[i] ^ (n3_h[i] >> 29);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 4; i++) begin
                r3_h[i] <= n3_h[i];
            end
            r3_sx <= r2_sx;
            r3_sy <= r2_sy;
        end
    end

    // stage 4: final multiply partials
    t_pp         r4_pp [4];
    logic [15:0] r4_sx, r4_sy;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 4; i++) begin
                r4_pp[i] <= fbm_pp(r3_h[i], HASH_K3);
            end
            r4_sx <= r3_sx;
            r4_sy <= r3_sy;
        end
    end

    // stage 5: second xorshift, corner values
    logic [15:0] r5_cv [4];
    logic [15:0] r5_sx, r5_sy;
    logic [63:0] n5_j [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n5_j[i] = fbm_pj(r4_pp[i]);
            n5_j[i] = n5_j[i] ^ (n5_j[i] >> 32);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 4; i++) begin
                r5_cv[i] <= n5_j[i][63:48] & VMASK;
            end
            r5_sx <= r4_sx;
            r5_sy <= r4_sy;
        end
    end

    // stage 6 and 7: bilinear blend
    logic [15:0] r6_ab, r6_cd, r6_sy, r7_v;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r6_ab <= fbm_blend(r5_cv[0], r5_cv[1], r5_sx);
            r6_cd <= fbm_blend(r5_cv[2], r5_cv[3], r5_sx);
            r6_sy <= r5_sy;
            r7_v  <= fbm_blend(r6_ab, r6_cd, r6_sy);
        end
    end

    // carry line and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= 7; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (i_adv) begin
            r_vld[1] <= i_bus.valid;
            for (int i = 2; i <= 7; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cr[1] <= n1_cr;
            for (int i = 2; i <= 7; i++) begin
                r_cr[i] <= r_cr[i-1];
            end
        end
    end

    // stage 8: weighted accumulate
    logic [31:0] n8_av;
    t_oct_bus    n_out;

    always_comb begin
        n8_av       = r_cr[7].amp * r7_v;
        n_out.valid = r_vld[7];
        n_out.cx    = r_cr[7].cx;
        n_out.cy    = r_cr[7].cy;
        n_out.amp   = r_cr[7].amp_n;
        n_out.sum   = r_cr[7].sum;
        n_out.norm  = r_cr[7].norm;
        if (i_active) begin
            n_out.sum  = r_cr[7].sum + SUM_W'(n8_av);
            n_out.norm = r_cr[7].norm + NORM_W'(r_cr[7].amp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (i_adv) begin
            r_out <= n_out;
        end
    end

    assign o_bus = r_out;

endmodule

`default_nettype wire

### rtl/fbm_div_cell.sv
`default_nettype none

module fbm_div_cell import fbm_pkg::*; #(
    parameter int BIT = 0
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_adv,
    input  wire t_div_bus i_bus,
    output t_div_bus      o_bus
);

    t_div_bus         r_out;
    t_div_bus         n_out;
    logic [SUM_W-1:0] n_dv;

    // one restoring step for one quotient bit
    always_comb begin
        n_dv  = SUM_W'(i_bus.norm) << BIT;
        n_out = i_bus;
        if (i_bus.rem >= n_dv) begin
            n_out.rem    = i_bus.rem - n_dv;
            n_out.q[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (i_adv) begin
            r_out <= n_out;
        end
    end

    assign o_bus = r_out;

endmodule

`default_nettype wire

### rtl/fbm_value_noise.sv
`default_nettype none

// Fractal value noise: one signed Q16.16 point (x, y) in, one Q0.16 noise value out.
// A new point is taken every cycle while the output is not stalled. Each octave cell
// is an eight-stage pipeline (two split 64-bit hash multiplies, fade, two blends,
// accumulate), followed by sixteen one-bit divider cells that normalize by the
// amplitude sum, and an output register. The whole chain freezes while a finished
// result waits on a stalled output. Octave count, lacunarity and gain must only be
// written while no point is in flight.

module fbm_value_noise import fbm_pkg::*; #(
    parameter int MAX_OCTAVES   = 8,
    parameter int HASH_OUT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_point_x,
    input  wire logic [31:0] i_point_y,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_noise_value
);

    logic [3:0]  r_octaves;
    logic [15:0] r_lacun;
    logic [15:0] r_gain;
    logic        w_adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octaves <= RST_OCTAVES;
            r_lacun   <= RST_LACUN;
            r_gain    <= RST_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OCTAVES: r_octaves <= i_cfg_data[3:0];
                CFG_LACUN:   r_lacun   <= i_cfg_data;
                CFG_GAIN:    r_gain    <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // whole chain moves unless the output holds a stalled result
    assign w_adv      = !o_out_valid || !i_out_stall;
    assign o_in_stall = !w_adv;

    // octave chain
    t_oct_bus w_oct [0:MAX_OCTAVES];

    always_comb begin
        w_oct[0].valid = i_in_valid;
        w_oct[0].cx    = {{16{i_point_x[31]}}, i_point_x};
        w_oct[0].cy    = {{16{i_point_y[31]}}, i_point_y};
        w_oct[0].amp   = AMP_INIT;
        w_oct[0].sum   = '0;
        w_oct[0].norm  = '0;
    end

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
        fbm_octave_cell #(
            .HASH_OUT_BITS(HASH_OUT_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_active (5'(g) < {1'b0, r_octaves}),
            .i_lac    (r_lacun),
            .i_gain   (r_gain),
            .i_bus    (w_oct[g]),
            .o_bus    (w_oct[g+1])
        );
    end

    // normalizing divider chain
    t_div_bus w_div [0:Q_W];

    always_comb begin
        w_div[0].valid = w_oct[MAX_OCTAVES].valid;
        w_div[0].rem   = w_oct[MAX_OCTAVES].sum;
        w_div[0].norm  = w_oct[MAX_OCTAVES].norm;
        w_div[0].q     = '0;
    end

    for (genvar g = 0; g < Q_W; g++) begin : g_div
        fbm_div_cell #(
            .BIT(Q_W - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_bus   (w_div[g]),
            .o_bus   (w_div[g+1])
        );
    end

    // output register, zero when no octave contributed
    logic        r_out_valid;
    logic [15:0] r_noise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_div[Q_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_noise <= (w_div[Q_W].norm == '0) ? '0 : w_div[Q_W].q;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_noise;

endmodule

`default_nettype wire

### rtl/fbm_chk.sv
`default_nettype none

module fbm_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_stall,
    input wire logic        i_out_valid,
    input wire logic        i_out_stall,
    input wire logic [15:0] i_noise_value
);

    // a stalled result stays and holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_noise_value))
        else $error("stalled result changed");

    // input is held back exactly while a result is blocked
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |-> i_in_stall)
        else $error("transfer taken while output blocked");

    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || !i_out_stall |-> !i_in_stall)
        else $error("input stalled with output free");

    // nothing comes out right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

endmodule

bind fbm_value_noise fbm_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_stall    (o_in_stall),
    .i_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .i_noise_value (o_noise_value)
);

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb;
    import fbm_pkg::*;

    localparam int OCT_MAX = 8;
    localparam int LATENCY = 8 * OCT_MAX + 17;

    // register index with no register behind it
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_point_x;
    logic [31:0] i_point_y;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_noise_value;

    // predictor copy of the registers
    logic [3:0]  cfg_octaves;
    logic [15:0] cfg_lacun;
    logic [15:0] cfg_gain;

    logic [15:0] noise_fifo[$];
    int          err_count;
    int          stall_mode = 1;

    fbm_value_noise dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_point_x(i_point_x), .i_point_y(i_point_y),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_noise_value(o_noise_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("** fbm_value_noise: FAILED **");
        $finish;
    end

    // lattice corner hash, top 16 bits
    function automatic logic [15:0] lattice_hash(input logic [63:0] cx, input logic [63:0] cy);
        logic [63:0] h;
        h = (cx * HASH_K1) ^ (cy * HASH_K2);
        h = h ^ (h >> 29);
        h = h * HASH_K3;
        h = h ^ (h >> 32);
        return h[63:48];
    endfunction

    function automatic logic [15:0] fade(input logic [15:0] t);
        logic [63:0] t2;
        logic [63:0] k;
        logic [63:0] r;
        t2 = ({48'd0, t} * {48'd0, t}) >> 16;
        k  = 64'd196608 - 2 * {48'd0, t};
        r  = (t2 * k) >> 16;
        return r[15:0];
    endfunction

    function automatic logic [15:0] mix(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] s);
        logic [63:0] r;
        r = ({48'd0, a} * (64'd65536 - s) + {48'd0, b} * s) >> 16;
        return r[15:0];
    endfunction

    function automatic logic [15:0] octave_noise(input logic [47:0] cx, input logic [47:0] cy);
        logic [63:0] ix;
        logic [63:0] iy;
        logic [15:0] sx;
        logic [15:0] sy;
        ix = {{32{cx[47]}}, cx[47:16]};
        iy = {{32{cy[47]}}, cy[47:16]};
        sx = fade(cx[15:0]);
        sy = fade(cy[15:0]);
        return mix(mix(lattice_hash(ix, iy), lattice_hash(ix + 1, iy), sx),
                   mix(lattice_hash(ix, iy + 1), lattice_hash(ix + 1, iy + 1), sx), sy);
    endfunction

    function automatic logic [47:0] rescale(input logic [47:0] c, input logic [15:0] lac);
        logic signed [79:0] p;
        p = $signed({{32{c[47]}}, c}) * $signed({64'd0, lac});
        p = p >>> 12;
        return p[47:0];
    endfunction

    function automatic logic [15:0] fbm_noise(input logic [31:0] px, input logic [31:0] py);
        logic [47:0] cx;
        logic [47:0] cy;
        logic [63:0] amp;
        logic [63:0] sum;
        logic [63:0] norm;
        logic [63:0] q;
        int          n;
        cx = {{16{px[31]}}, px};
        cy = {{16{py[31]}}, py};
        amp = 64'd32768;
        sum = 0;
        norm = 0;
        n = (cfg_octaves > OCT_MAX) ? OCT_MAX : cfg_octaves;
        for (int i = 0; i < n; i++) begin
            sum  = sum + amp * octave_noise(cx, cy);
            norm = norm + amp;
            cx   = rescale(cx, cfg_lacun);
            cy   = rescale(cy, cfg_lacun);
            amp  = (amp * cfg_gain) >> 16;
        end
        q = (norm != 0) ? sum / norm : 0;
        return q[15:0];
    endfunction

    // receiver stall pattern
    always @(posedge i_clk) begin
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 1) == 0);
        endcase
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (noise_fifo.size() == 0) begin
                $error("noise_value: unexpected transfer, actual %0d", o_noise_value);
                err_count++;
            end else begin
                if (o_noise_value !== noise_fifo[0]) begin
                    $error("noise_value: expected %0d actual %0d",
                           noise_fifo[0], o_noise_value);
                    err_count++;
                end
                void'(noise_fifo.pop_front());
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_OCTAVES: cfg_octaves = val[3:0];
            CFG_LACUN:   cfg_lacun = val;
            CFG_GAIN:    cfg_gain = val;
            default: ;
        endcase
    endtask

    // drain in-flight points before touching registers
    task automatic drain();
        while (noise_fifo.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [3:0] oc, input logic [15:0] lac,
                              input logic [15:0] g);
        drain();
        write_reg(CFG_OCTAVES, {12'd0, oc});
        write_reg(CFG_LACUN, lac);
        write_reg(CFG_GAIN, g);
    endtask

    // one point transfer, holds valid through stalls
    task automatic send_point(input logic [31:0] px, input logic [31:0] py);
        i_in_valid <= 1'b1;
        i_point_x  <= px;
        i_point_y  <= py;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        noise_fifo.push_back(fbm_noise(px, py));
    endtask

    task automatic idle_gap();
        i_in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [31:0] corners[6];
        corners = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h0000FFFF, 32'h00010000};
        foreach (corners[i]) send_point(corners[i], corners[5 - i]);
        send_point(32'hFFFF0000, 32'h0001FFFF);
        send_point(32'h12345678, 32'h9ABCDEF0);
        idle_gap();
    endtask

    task automatic test_random(input int count);
        int burst;
        int sent;
        logic [31:0] px;
        logic [31:0] py;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst && sent < count; i++) begin
                case ($urandom_range(0, 3))
                    0: begin
                        px = {{16{1'b0}}, 16'($urandom)} + ($urandom_range(0, 20) << 16);
                        py = {{16{1'b0}}, 16'($urandom)} - ($urandom_range(0, 20) << 16);
                    end
                    default: begin
                        px = $urandom;
                        py = $urandom;
                    end
                endcase
                send_point(px, py);
                sent++;
            end
            if ($urandom_range(0, 2) != 0) idle_gap();
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic test_octave_settings();
        set_config(4'd0, 16'd8192, 16'd32768);
        test_directed();
        set_config(4'd1, 16'd4096, 16'd65535);
        test_random(60);
        set_config(4'd8, 16'd65535, 16'd65535);
        test_random(60);
        set_config(4'd15, 16'd0, 16'd0);
        test_directed();
        test_random(40);
        set_config(4'd9, 16'd12345, 16'd1);
        test_random(40);
    endtask

    task automatic test_random_config();
        for (int k = 0; k < 4; k++) begin
            set_config(4'($urandom_range(0, 15)), 16'($urandom), 16'($urandom));
            test_random(60);
        end
        // out-of-range index must be ignored
        drain();
        write_reg(CFG_UNUSED, 16'hFFFF);
        test_random(30);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = 2'd0;
        i_cfg_data = 16'd0;
        i_in_valid = 1'b0;
        i_point_x  = 32'd0;
        i_point_y  = 32'd0;
        err_count  = 0;
        cfg_octaves = 4'd4;
        cfg_lacun  = 16'd8192;
        cfg_gain   = 16'd32768;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(120);
        test_octave_settings();
        test_random_config();

        drain();
        if (err_count == 0) begin
            $display("** fbm_value_noise: PASSED **");
        end else begin
            $display("** fbm_value_noise: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
